@@ rtl/ccrc_pkg.sv @@
// Shared types, constants and window tests for the coin classifier and roll counter.
// No dependencies; every other rtl file refers to it by scoped names.
package ccrc_pkg;

  localparam int DEFAULT_COUNTER_WIDTH = 16;
  localparam int QUEUE_DEPTH = 4;
  localparam int NUM_ROLLS = 5;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 13;
  localparam int SIZE_W = 6;
  localparam int SUM_W = 13;
  localparam int TOTAL_W = 24;
  localparam int OUT_CNT_W = 16;

  typedef enum logic [2:0] {
    DEST_NICKEL  = 3'd0,
    DEST_DIME    = 3'd1,
    DEST_QUARTER = 3'd2,
    DEST_LOONIE  = 3'd3,
    DEST_TOONIE  = 3'd4,
    DEST_BENT    = 3'd5,
    DEST_OTHER   = 3'd6
  } dest_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_NICKEL_SIZE  = 3'd0,
    CFG_DIME_SIZE    = 3'd1,
    CFG_QUARTER_SIZE = 3'd2,
    CFG_LOONIE_SIZE  = 3'd3,
    CFG_TOONIE_SIZE  = 3'd4,
    CFG_BENT_LIMIT   = 3'd5,
    CFG_OTHER_LIMIT  = 3'd6
  } cfg_index_t;

  localparam logic [SIZE_W-1:0] SIZE_RESET [NUM_ROLLS] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
  localparam logic [SUM_W-1:0] BENT_LIMIT_RESET = 13'd2550;
  localparam logic [SUM_W-1:0] OTHER_LIMIT_RESET = 13'd5100;

  // Windows in hundredths, pre-scaled by 255 so the test is a cross-multiply.
  localparam logic [19:0] WGT_LO [NUM_ROLLS] =
    '{20'(360 * 255), 20'(130 * 255), 20'(400 * 255), 20'(650 * 255), 20'(675 * 255)};
  localparam logic [19:0] WGT_HI [NUM_ROLLS] =
    '{20'(430 * 255), 20'(220 * 255), 20'(480 * 255), 20'(750 * 255), 20'(785 * 255)};
  localparam logic [19:0] DIA_LO [NUM_ROLLS] =
    '{20'(2020 * 255), 20'(1730 * 255), 20'(2280 * 255), 20'(2500 * 255), 20'(2690 * 255)};
  localparam logic [19:0] DIA_HI [NUM_ROLLS] =
    '{20'(2180 * 255), 20'(1870 * 255), 20'(2460 * 255), 20'(2700 * 255), 20'(2910 * 255)};

  typedef struct packed {
    logic [NUM_ROLLS-1:0][SIZE_W-1:0] roll_size;
    logic [SUM_W-1:0]                 bent_limit;
    logic [SUM_W-1:0]                 other_limit;
  } cfg_t;

  // One classified coin waiting for the counters.
  typedef struct packed {
    dest_t      dest;
    logic [7:0] weight;
  } job_t;

  typedef struct packed {
    dest_t                destination;
    logic                 replaced;
    logic [OUT_CNT_W-1:0] coins_in_container;
    logic [SUM_W-1:0]     container_raw_weight;
    logic [OUT_CNT_W-1:0] completed_count;
    logic [TOTAL_W-1:0]   total_raw_weight;
    logic [OUT_CNT_W-1:0] total_coins;
  } result_t;

  // Weight g*100*255 = raw*1000; diameter mm*100*255 = 255000 + raw*3000.
  function automatic logic fits(input logic [2:0] k, input logic [7:0] w,
                                input logic [7:0] d);
    logic [19:0] wv;
    logic [19:0] dv;
    wv = 20'(w) * 20'd1000;
    dv = 20'd255000 + 20'(d) * 20'd3000;
    return (wv >= WGT_LO[k]) && (wv <= WGT_HI[k]) &&
           (dv >= DIA_LO[k]) && (dv <= DIA_HI[k]);
  endfunction

endpackage

@@ rtl/ccrc_front.sv @@
// Front end: classifies one incoming coin into its destination.
// Depends on ccrc_pkg.
module ccrc_front (
  input  logic [7:0]     weight_reading,
  input  logic [7:0]     diameter_reading,
  input  logic           is_bent,
  input  logic [1:0]     face_match,
  output ccrc_pkg::job_t job
);

  logic [ccrc_pkg::NUM_ROLLS-1:0] hit;
  logic                           both_faces;

  assign both_faces = (face_match == 2'd2);

  always_comb begin
    for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++) begin
      hit[k] = both_faces && ccrc_pkg::fits(3'(k), weight_reading, diameter_reading);
    end
  end

  // Priority: bent, then the rolls in order, then other.
  always_comb begin
    job.weight = weight_reading;
    job.dest   = ccrc_pkg::DEST_OTHER;
    if (is_bent) begin
      job.dest = ccrc_pkg::DEST_BENT;
    end else begin
      for (int k = ccrc_pkg::NUM_ROLLS - 1; k >= 0; k--) begin
        if (hit[k]) begin
          job.dest = ccrc_pkg::dest_t'(3'(k));
        end
      end
    end
  end

endmodule

@@ rtl/ccrc_queue.sv @@
// Short queue between the classifier and the counters.
// Depends on ccrc_pkg (job_t, QUEUE_DEPTH).
module ccrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  ccrc_pkg::job_t push_job,
  input  logic           pop,
  output ccrc_pkg::job_t head_job,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = ccrc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  ccrc_pkg::job_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_job = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ rtl/ccrc_back.sv @@
// Back end: roll fills, container sums and saturating counters, plus the result register.
// Depends on ccrc_pkg (job_t, cfg_t, result_t, dest codes).
module ccrc_back #(
  parameter int COUNTER_WIDTH = ccrc_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  ccrc_pkg::cfg_t    cfg,
  input  logic              job_valid,
  input  ccrc_pkg::job_t    job,
  output logic              job_pop,
  output logic              res_valid,
  input  logic              res_ready,
  output ccrc_pkg::result_t res
);

  localparam int CW = COUNTER_WIDTH;
  localparam int NR = ccrc_pkg::NUM_ROLLS;
  localparam int SW = ccrc_pkg::SUM_W;
  localparam int TW = ccrc_pkg::TOTAL_W;
  localparam int OW = ccrc_pkg::OUT_CNT_W;
  localparam logic [CW-1:0] CNT_MAX = '1;
  localparam logic [TW-1:0] TOT_MAX = '1;

  logic [ccrc_pkg::SIZE_W-1:0] roll_fill [NR];
  logic [CW-1:0]               full_rolls [NR];
  logic [SW-1:0]               bent_sum, other_sum;
  logic [CW-1:0]               bent_containers, other_containers, other_partial_coins;
  logic [TW-1:0]               bent_total_raw, other_total_raw;
  logic [CW-1:0]               bent_total_coins, other_total_coins;

  logic [ccrc_pkg::SIZE_W-1:0] roll_fill_next [NR];
  logic [CW-1:0]               full_rolls_next [NR];
  logic [SW-1:0]               bent_sum_next, other_sum_next;
  logic [CW-1:0]               bent_containers_next, other_containers_next;
  logic [CW-1:0]               other_partial_coins_next;
  logic [TW-1:0]               bent_total_raw_next, other_total_raw_next;
  logic [CW-1:0]               bent_total_coins_next, other_total_coins_next;
  ccrc_pkg::result_t           res_next;

  function automatic logic [CW-1:0] inc_sat(input logic [CW-1:0] v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [TW-1:0] add_tot(input logic [TW-1:0] t, input logic [7:0] a);
    logic [TW:0] s;
    s = {1'b0, t} + (TW + 1)'(a);
    return s[TW] ? TOT_MAX : s[TW-1:0];
  endfunction

  assign job_pop = job_valid && (!res_valid || res_ready);

  always_comb begin
    logic [ccrc_pkg::SIZE_W:0] fill_inc;
    logic [SW:0]               sum_new;
    logic                      over;

    for (int k = 0; k < NR; k++) begin
      roll_fill_next[k]  = roll_fill[k];
      full_rolls_next[k] = full_rolls[k];
    end
    bent_sum_next            = bent_sum;
    other_sum_next           = other_sum;
    bent_containers_next     = bent_containers;
    other_containers_next    = other_containers;
    other_partial_coins_next = other_partial_coins;
    bent_total_raw_next      = bent_total_raw;
    other_total_raw_next     = other_total_raw;
    bent_total_coins_next    = bent_total_coins;
    other_total_coins_next   = other_total_coins;
    fill_inc                 = '0;
    sum_new                  = '0;
    over                     = 1'b0;
    res_next                 = '0;
    res_next.destination     = job.dest;

    unique case (job.dest) inside
      ccrc_pkg::DEST_NICKEL, ccrc_pkg::DEST_DIME, ccrc_pkg::DEST_QUARTER,
      ccrc_pkg::DEST_LOONIE, ccrc_pkg::DEST_TOONIE: begin
        for (int k = 0; k < NR; k++) begin
          if (job.dest == ccrc_pkg::dest_t'(3'(k))) begin
            fill_inc = {1'b0, roll_fill[k]} + 1'b1;
            if (fill_inc >= {1'b0, cfg.roll_size[k]}) begin
              roll_fill_next[k]  = '0;
              full_rolls_next[k] = inc_sat(full_rolls[k]);
              res_next.replaced  = 1'b1;
            end else begin
              roll_fill_next[k] = fill_inc[ccrc_pkg::SIZE_W-1:0];
            end
            res_next.coins_in_container = OW'(roll_fill_next[k]);
            res_next.completed_count    = OW'(full_rolls_next[k]);
          end
        end
      end
      ccrc_pkg::DEST_BENT: begin
        bent_total_coins_next = inc_sat(bent_total_coins);
        bent_total_raw_next   = add_tot(bent_total_raw, job.weight);
        sum_new               = {1'b0, bent_sum} + (SW + 1)'(job.weight);
        over                  = (sum_new > {1'b0, cfg.bent_limit});
        if (over) begin
          bent_containers_next = inc_sat(bent_containers);
          bent_sum_next        = SW'(job.weight);
        end else begin
          bent_sum_next = sum_new[SW-1:0];
        end
        res_next.replaced             = over;
        res_next.container_raw_weight = bent_sum_next;
        res_next.completed_count      = OW'(bent_containers_next);
        res_next.total_raw_weight     = bent_total_raw_next;
        res_next.total_coins          = OW'(bent_total_coins_next);
      end
      default: begin
        other_total_coins_next = inc_sat(other_total_coins);
        other_total_raw_next   = add_tot(other_total_raw, job.weight);
        sum_new                = {1'b0, other_sum} + (SW + 1)'(job.weight);
        over                   = (sum_new > {1'b0, cfg.other_limit});
        if (over) begin
          other_containers_next    = inc_sat(other_containers);
          other_sum_next           = SW'(job.weight);
          other_partial_coins_next = CW'(1);
        end else begin
          other_sum_next           = sum_new[SW-1:0];
          other_partial_coins_next = inc_sat(other_partial_coins);
        end
        res_next.replaced             = over;
        res_next.coins_in_container   = OW'(other_partial_coins_next);
        res_next.container_raw_weight = other_sum_next;
        res_next.completed_count      = OW'(other_containers_next);
        res_next.total_raw_weight     = other_total_raw_next;
        res_next.total_coins          = OW'(other_total_coins_next);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NR; k++) begin
        roll_fill[k]  <= '0;
        full_rolls[k] <= '0;
      end
      bent_sum            <= '0;
      other_sum           <= '0;
      bent_containers     <= '0;
      other_containers    <= '0;
      other_partial_coins <= '0;
      bent_total_raw      <= '0;
      other_total_raw     <= '0;
      bent_total_coins    <= '0;
      other_total_coins   <= '0;
      res_valid           <= 1'b0;
    end else begin
      if (job_pop) begin
        for (int k = 0; k < NR; k++) begin
          roll_fill[k]  <= roll_fill_next[k];
          full_rolls[k] <= full_rolls_next[k];
        end
        bent_sum            <= bent_sum_next;
        other_sum           <= other_sum_next;
        bent_containers     <= bent_containers_next;
        other_containers    <= other_containers_next;
        other_partial_coins <= other_partial_coins_next;
        bent_total_raw      <= bent_total_raw_next;
        other_total_raw     <= other_total_raw_next;
        bent_total_coins    <= bent_total_coins_next;
        other_total_coins   <= other_total_coins_next;
        res_valid           <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  ccrc_pkg::result_t res_q;

  always_ff @(posedge clk) begin
    if (job_pop) begin
      res_q <= res_next;
    end
  end

  assign res = res_q;

endmodule

@@ rtl/coin_classify_and_roll_count_unit.sv @@
// Coin classifier and roll counter, top level.
// Depends on ccrc_pkg, ccrc_front, ccrc_queue and ccrc_back.
//
// One coin per beat goes in, one result per coin comes out, in order. The
// sustained rate is one coin per clock while out_ready is high: the classifier
// is pure logic in front of a four-entry queue, and the counter stage updates
// all of its state at once from the head of that queue. A coin at the head
// moves into the result register whenever that register is empty or being
// read. The queue and the result register let input and output stall
// independently; in_ready drops only once four coins sit waiting. Coins are
// classified in priority order bent, nickel, dime, quarter, loonie, toonie,
// other; a roll needs both faces matched. Weight and diameter windows are
// tested exactly by cross-multiplying the raw readings against constants.
// Configuration registers (roll sizes, container limits) take a write every
// cycle and must only be written while no coin is in flight.
module coin_classify_and_roll_count_unit #(
  parameter int COUNTER_WIDTH = ccrc_pkg::DEFAULT_COUNTER_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst,
  // coin input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         weight_reading,
  input  logic [7:0]                         diameter_reading,
  input  logic                               is_bent,
  input  logic [1:0]                         face_match,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [2:0]                         destination,
  output logic                               replaced,
  output logic [ccrc_pkg::OUT_CNT_W-1:0]     coins_in_container,
  output logic [ccrc_pkg::SUM_W-1:0]         container_raw_weight,
  output logic [ccrc_pkg::OUT_CNT_W-1:0]     completed_count,
  output logic [ccrc_pkg::TOTAL_W-1:0]       total_raw_weight,
  output logic [ccrc_pkg::OUT_CNT_W-1:0]     total_coins,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ccrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [ccrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ccrc_pkg::cfg_t    cfg;
  ccrc_pkg::job_t    front_job;
  ccrc_pkg::job_t    head_job;
  ccrc_pkg::result_t res;
  logic              q_full, q_empty, q_push, q_pop;

  // Config beats are always taken; an index past the list is dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++) begin
        cfg.roll_size[k] <= ccrc_pkg::SIZE_RESET[k];
      end
      cfg.bent_limit  <= ccrc_pkg::BENT_LIMIT_RESET;
      cfg.other_limit <= ccrc_pkg::OTHER_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index) inside
        ccrc_pkg::CFG_NICKEL_SIZE, ccrc_pkg::CFG_DIME_SIZE, ccrc_pkg::CFG_QUARTER_SIZE,
        ccrc_pkg::CFG_LOONIE_SIZE, ccrc_pkg::CFG_TOONIE_SIZE: begin
          cfg.roll_size[cfg_index] <= cfg_data[ccrc_pkg::SIZE_W-1:0];
        end
        ccrc_pkg::CFG_BENT_LIMIT: begin
          cfg.bent_limit <= cfg_data[ccrc_pkg::SUM_W-1:0];
        end
        ccrc_pkg::CFG_OTHER_LIMIT: begin
          cfg.other_limit <= cfg_data[ccrc_pkg::SUM_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Front: classify straight into the queue.
  ccrc_front u_front (
    .weight_reading   (weight_reading),
    .diameter_reading (diameter_reading),
    .is_bent          (is_bent),
    .face_match       (face_match),
    .job              (front_job)
  );

  assign in_ready = !q_full;
  assign q_push   = in_valid && in_ready;

  ccrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .head_job (head_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back: counters and the result register.
  ccrc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .job_valid (!q_empty),
    .job       (head_job),
    .job_pop   (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign destination          = res.destination;
  assign replaced             = res.replaced;
  assign coins_in_container   = res.coins_in_container;
  assign container_raw_weight = res.container_raw_weight;
  assign completed_count      = res.completed_count;
  assign total_raw_weight     = res.total_raw_weight;
  assign total_coins          = res.total_coins;

endmodule

@@ rtl/ccrc_checker.sv @@
// Port-level checks for the coin classifier and roll counter, and their bind.
// Depends on ccrc_pkg (dest codes) and the top level's ports.
module ccrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  destination,
  input logic        replaced,
  input logic [15:0] coins_in_container,
  input logic [12:0] container_raw_weight,
  input logic [23:0] total_raw_weight,
  input logic [15:0] total_coins
);

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(destination) && $stable(total_coins))
    else $error("result changed while stalled");

  a_dest: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> destination <= ccrc_pkg::DEST_OTHER)
    else $error("destination code out of range");

  // Rolls carry no container weight or totals.
  a_roll_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination < ccrc_pkg::DEST_BENT |->
      container_raw_weight == 13'd0 && total_raw_weight == 24'd0 && total_coins == 16'd0)
    else $error("roll result carries container fields");

  a_bent_coins: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination == ccrc_pkg::DEST_BENT |->
      coins_in_container == 16'd0 && total_coins != 16'd0)
    else $error("bent result coin fields wrong");

  // A fresh other container holds just this coin.
  a_other_restart: assert property (@(posedge clk) disable iff (rst)
    out_valid && destination == ccrc_pkg::DEST_OTHER && replaced |->
      coins_in_container == 16'd1)
    else $error("other container did not restart at one coin");

endmodule

bind coin_classify_and_roll_count_unit ccrc_checker u_ccrc_checker (.*);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for coin_classify_and_roll_count_unit.
// Depends on ccrc_pkg and the rtl under rtl/; a local predictor scores every result beat.
module tb;

  // Face codes as driven on face_match; only FACE_BOTH lets a coin reach a roll.
  localparam logic [1:0] FACE_NONE  = 2'd0;
  localparam logic [1:0] FACE_ONE   = 2'd1;
  localparam logic [1:0] FACE_BOTH  = 2'd2;
  localparam logic [1:0] FACE_UNDEF = 2'd3;
  // Index with no register behind it; a write there must change nothing.
  localparam logic [ccrc_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

  localparam logic [ccrc_pkg::OUT_CNT_W-1:0] COUNT_MAX = '1;
  localparam logic [ccrc_pkg::TOTAL_W-1:0]   RAW_TOTAL_MAX = '1;

  // Coin windows in hundredths of a gram and of a millimetre, inclusive.
  localparam int WIN_W_LO [ccrc_pkg::NUM_ROLLS] = '{360, 130, 400, 650, 675};
  localparam int WIN_W_HI [ccrc_pkg::NUM_ROLLS] = '{430, 220, 480, 750, 785};
  localparam int WIN_D_LO [ccrc_pkg::NUM_ROLLS] = '{2020, 1730, 2280, 2500, 2690};
  localparam int WIN_D_HI [ccrc_pkg::NUM_ROLLS] = '{2180, 1870, 2460, 2700, 2910};

  // Same windows as raw sensor codes, only used to aim the stimulus.
  localparam int AIM_W_LO [ccrc_pkg::NUM_ROLLS] = '{92, 34, 102, 166, 173};
  localparam int AIM_W_HI [ccrc_pkg::NUM_ROLLS] = '{109, 56, 122, 191, 200};
  localparam int AIM_D_LO [ccrc_pkg::NUM_ROLLS] = '{87, 63, 109, 128, 144};
  localparam int AIM_D_HI [ccrc_pkg::NUM_ROLLS] = '{100, 73, 124, 144, 162};

  localparam int MAX_PRINTED = 30;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                in_valid = 1'b0;
  logic                                in_ready;
  logic [7:0]                          weight_reading = '0;
  logic [7:0]                          diameter_reading = '0;
  logic                                is_bent = 1'b0;
  logic [1:0]                          face_match = '0;

  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic [2:0]                          destination;
  logic                                replaced;
  logic [ccrc_pkg::OUT_CNT_W-1:0]      coins_in_container;
  logic [ccrc_pkg::SUM_W-1:0]          container_raw_weight;
  logic [ccrc_pkg::OUT_CNT_W-1:0]      completed_count;
  logic [ccrc_pkg::TOTAL_W-1:0]        total_raw_weight;
  logic [ccrc_pkg::OUT_CNT_W-1:0]      total_coins;

  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ccrc_pkg::CFG_INDEX_W-1:0]    cfg_index = '0;
  logic [ccrc_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  coin_classify_and_roll_count_unit u_top (
    .clk                  (clk),
    .rst                  (rst),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .weight_reading       (weight_reading),
    .diameter_reading     (diameter_reading),
    .is_bent              (is_bent),
    .face_match           (face_match),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .destination          (destination),
    .replaced             (replaced),
    .coins_in_container   (coins_in_container),
    .container_raw_weight (container_raw_weight),
    .completed_count      (completed_count),
    .total_raw_weight     (total_raw_weight),
    .total_coins          (total_coins),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow configuration and sorter state, kept in step with the design.
  // ---------------------------------------------------------------------------
  logic [ccrc_pkg::SIZE_W-1:0]    roll_size_cfg [ccrc_pkg::NUM_ROLLS] = ccrc_pkg::SIZE_RESET;
  logic [ccrc_pkg::SUM_W-1:0]     bent_limit_cfg = ccrc_pkg::BENT_LIMIT_RESET;
  logic [ccrc_pkg::SUM_W-1:0]     other_limit_cfg = ccrc_pkg::OTHER_LIMIT_RESET;

  logic [ccrc_pkg::SIZE_W-1:0]    roll_fill_st [ccrc_pkg::NUM_ROLLS] = '{default: '0};
  logic [ccrc_pkg::OUT_CNT_W-1:0] rolls_done [ccrc_pkg::NUM_ROLLS] = '{default: '0};
  logic [ccrc_pkg::SUM_W-1:0]     bent_fill = '0;
  logic [ccrc_pkg::SUM_W-1:0]     other_fill = '0;
  logic [ccrc_pkg::OUT_CNT_W-1:0] bent_swaps = '0;
  logic [ccrc_pkg::OUT_CNT_W-1:0] other_swaps = '0;
  logic [ccrc_pkg::OUT_CNT_W-1:0] other_loose = '0;
  logic [ccrc_pkg::TOTAL_W-1:0]   bent_raw_total = '0;
  logic [ccrc_pkg::TOTAL_W-1:0]   other_raw_total = '0;
  logic [ccrc_pkg::OUT_CNT_W-1:0] bent_coin_total = '0;
  logic [ccrc_pkg::OUT_CNT_W-1:0] other_coin_total = '0;

  // Results owed by the design, oldest first.
  ccrc_pkg::result_t expected_results [$];
  int unsigned mismatches = 0;

  function automatic logic [ccrc_pkg::OUT_CNT_W-1:0] bump_count(
      input logic [ccrc_pkg::OUT_CNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + 1'b1;
  endfunction

  function automatic logic [ccrc_pkg::TOTAL_W-1:0] add_raw_total(
      input logic [ccrc_pkg::TOTAL_W-1:0] t, input logic [7:0] w);
    logic [ccrc_pkg::TOTAL_W:0] s;
    s = {1'b0, t} + (ccrc_pkg::TOTAL_W+1)'(w);
    return (s > (ccrc_pkg::TOTAL_W+1)'(RAW_TOTAL_MAX)) ? RAW_TOTAL_MAX :
                                                         s[ccrc_pkg::TOTAL_W-1:0];
  endfunction

  // Window test scaled by 255 on both sides so it stays exact in integers.
  function automatic bit coin_fits(input int k, input logic [7:0] w, input logic [7:0] d);
    int wv;
    int dv;
    wv = int'(w) * 1000;
    dv = 255000 + int'(d) * 3000;
    return wv >= WIN_W_LO[k] * 255 && wv <= WIN_W_HI[k] * 255 &&
           dv >= WIN_D_LO[k] * 255 && dv <= WIN_D_HI[k] * 255;
  endfunction

  // Sorts one coin, advances the shadow state and returns the result it owes.
  function automatic ccrc_pkg::result_t classify_and_count(input logic [7:0] w,
                                                           input logic [7:0] d,
                                                           input logic b,
                                                           input logic [1:0] f);
    ccrc_pkg::result_t r;
    int slot;
    logic [ccrc_pkg::SUM_W:0] s;
    logic [ccrc_pkg::SIZE_W:0] nf;
    r = '0;
    slot = ccrc_pkg::NUM_ROLLS;
    if (b) begin
      r.destination = ccrc_pkg::DEST_BENT;
      bent_coin_total = bump_count(bent_coin_total);
      bent_raw_total = add_raw_total(bent_raw_total, w);
      s = {1'b0, bent_fill} + (ccrc_pkg::SUM_W+1)'(w);
      // container full: swap it and start the new one with this coin
      if (s > {1'b0, bent_limit_cfg}) begin
        bent_swaps = bump_count(bent_swaps);
        bent_fill = (ccrc_pkg::SUM_W)'(w);
        r.replaced = 1'b1;
      end else begin
        bent_fill = s[ccrc_pkg::SUM_W-1:0];
      end
      r.container_raw_weight = bent_fill;
      r.completed_count = bent_swaps;
      r.total_raw_weight = bent_raw_total;
      r.total_coins = bent_coin_total;
    end else begin
      // first matching window wins; face code 3 never counts as both
      for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++)
        if (slot == ccrc_pkg::NUM_ROLLS && f == FACE_BOTH && coin_fits(k, w, d))
          slot = k;
      if (slot < ccrc_pkg::NUM_ROLLS) begin
        r.destination = ccrc_pkg::dest_t'(slot);
        nf = {1'b0, roll_fill_st[slot]} + 1'b1;
        // at or past the size: also catches a size lowered under the fill, and size 0
        if (nf >= {1'b0, roll_size_cfg[slot]}) begin
          nf = '0;
          rolls_done[slot] = bump_count(rolls_done[slot]);
          r.replaced = 1'b1;
        end
        roll_fill_st[slot] = nf[ccrc_pkg::SIZE_W-1:0];
        r.coins_in_container = (ccrc_pkg::OUT_CNT_W)'(roll_fill_st[slot]);
        r.completed_count = rolls_done[slot];
      end else begin
        r.destination = ccrc_pkg::DEST_OTHER;
        other_coin_total = bump_count(other_coin_total);
        other_raw_total = add_raw_total(other_raw_total, w);
        s = {1'b0, other_fill} + (ccrc_pkg::SUM_W+1)'(w);
        if (s > {1'b0, other_limit_cfg}) begin
          other_swaps = bump_count(other_swaps);
          other_fill = (ccrc_pkg::SUM_W)'(w);
          other_loose = '0;
          r.replaced = 1'b1;
        end else begin
          other_fill = s[ccrc_pkg::SUM_W-1:0];
        end
        other_loose = bump_count(other_loose);
        r.coins_in_container = other_loose;
        r.container_raw_weight = other_fill;
        r.completed_count = other_swaps;
        r.total_raw_weight = other_raw_total;
        r.total_coins = other_coin_total;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: a stall pattern of its own, and the scoreboard.
  // ---------------------------------------------------------------------------
  int unsigned stall_cnt = 0;
  int unsigned stall_mode = 0;

  // Mode is redrawn at random periodically: always ready, coin toss, mostly
  // stalled, or a fixed 3-in-8 pattern, so stalls land on every phase of the queue.
  always @(posedge clk) begin
    stall_cnt <= stall_cnt + 1;
    if (stall_cnt % 48 == 0)
      stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (stall_cnt[2:0] < 3'd3);
    endcase
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    ccrc_pkg::result_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat, destination", destination, 0);
      end else begin
        want = expected_results.pop_front();
        if (destination != want.destination)
          report_mismatch("destination", destination, want.destination);
        if (replaced != want.replaced)
          report_mismatch("replaced", replaced, want.replaced);
        if (coins_in_container != want.coins_in_container)
          report_mismatch("coins_in_container", coins_in_container, want.coins_in_container);
        if (container_raw_weight != want.container_raw_weight)
          report_mismatch("container_raw_weight", container_raw_weight,
                          want.container_raw_weight);
        if (completed_count != want.completed_count)
          report_mismatch("completed_count", completed_count, want.completed_count);
        if (total_raw_weight != want.total_raw_weight)
          report_mismatch("total_raw_weight", total_raw_weight, want.total_raw_weight);
        if (total_coins != want.total_coins)
          report_mismatch("total_coins", total_coins, want.total_coins);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Coin and register drivers.
  // ---------------------------------------------------------------------------

  // Holds one coin beat until taken. Valid is left high so a following call at
  // the same edge streams without a bubble; stop_coins drops it.
  task automatic send_coin(input logic [7:0] w, input logic [7:0] d, input logic b,
                           input logic [1:0] f);
    weight_reading <= w;
    diameter_reading <= d;
    is_bent <= b;
    face_match <= f;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_results.push_back(classify_and_count(w, d, b, f));
  endtask

  task automatic stop_coins(input int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Register writes only go in once the unit has drained: every owed result
  // read out, then an idle wait before the write.
  task automatic write_reg(input logic [ccrc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [ccrc_pkg::CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < ccrc_pkg::NUM_ROLLS)
      roll_size_cfg[idx] = val[ccrc_pkg::SIZE_W-1:0];
    else if (idx == ccrc_pkg::CFG_BENT_LIMIT)
      bent_limit_cfg = val[ccrc_pkg::SUM_W-1:0];
    else if (idx == ccrc_pkg::CFG_OTHER_LIMIT)
      other_limit_cfg = val[ccrc_pkg::SUM_W-1:0];
  endtask

  function automatic logic [7:0] aim_near(input int lo, input int hi);
    int a;
    int z;
    a = (lo < 2) ? 0 : lo - 2;
    z = (hi > 253) ? 255 : hi + 2;
    return 8'($urandom_range(a, z));
  endfunction

  // Mostly coins aimed at a roll window (edges included), some near misses on
  // the faces, the rest pure noise and bent coins.
  task automatic random_coin();
    int pick;
    int k;
    logic [7:0] w;
    logic [7:0] d;
    logic b;
    logic [1:0] f;
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, ccrc_pkg::NUM_ROLLS - 1);
    w = aim_near(AIM_W_LO[k], AIM_W_HI[k]);
    d = aim_near(AIM_D_LO[k], AIM_D_HI[k]);
    b = ($urandom_range(0, 9) == 0);
    f = FACE_BOTH;
    if (pick >= 85) begin
      w = 8'($urandom_range(0, 255));
      d = 8'($urandom_range(0, 255));
      b = 1'($urandom_range(0, 1));
      f = 2'($urandom_range(0, 3));
    end else if (pick >= 70) begin
      f = 2'($urandom_range(0, 3));
    end
    send_coin(w, d, b, f);
  endtask

  // Bursts of random length; gap_pct sets how often a burst is followed by idle.
  task automatic run_random(input int unsigned count, input int unsigned gap_pct);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 16);
      while (burst > 0 && sent < count) begin
        random_coin();
        burst--;
        sent++;
      end
      if ($urandom_range(1, 100) <= gap_pct)
        stop_coins($urandom_range(1, 6));
    end
    stop_coins(1);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset settings: window edges, priority overlaps, face codes and field extremes.
  task automatic test_default_sorting();
    send_coin(8'd92, 8'd87, 1'b0, FACE_BOTH);     // nickel, low corner
    send_coin(8'd109, 8'd100, 1'b0, FACE_BOTH);   // nickel, high corner
    send_coin(8'd91, 8'd90, 1'b0, FACE_BOTH);     // one code light of nickel
    send_coin(8'd34, 8'd63, 1'b0, FACE_BOTH);     // dime, low corner
    send_coin(8'd56, 8'd73, 1'b0, FACE_BOTH);     // dime, high corner
    send_coin(8'd40, 8'd62, 1'b0, FACE_BOTH);     // diameter just under dime
    send_coin(8'd102, 8'd109, 1'b0, FACE_BOTH);   // quarter, weight exactly on edge
    send_coin(8'd122, 8'd124, 1'b0, FACE_BOTH);   // quarter, high corner
    send_coin(8'd166, 8'd128, 1'b0, FACE_BOTH);   // loonie, low corner
    send_coin(8'd191, 8'd144, 1'b0, FACE_BOTH);   // loonie, high corner
    send_coin(8'd180, 8'd144, 1'b0, FACE_BOTH);   // fits loonie and toonie: loonie wins
    send_coin(8'd173, 8'd162, 1'b0, FACE_BOTH);   // toonie
    send_coin(8'd200, 8'd150, 1'b0, FACE_BOTH);   // toonie, heavy edge
    send_coin(8'd100, 8'd90, 1'b0, FACE_ONE);     // nickel shape, one face
    send_coin(8'd100, 8'd90, 1'b0, FACE_NONE);
    send_coin(8'd100, 8'd90, 1'b0, FACE_UNDEF);   // undefined face code is not a match
    send_coin(8'd100, 8'd90, 1'b1, FACE_BOTH);    // bent beats every roll
    send_coin(8'd255, 8'd255, 1'b1, FACE_UNDEF);
    send_coin(8'd0, 8'd0, 1'b0, FACE_NONE);
    send_coin(8'd255, 8'd255, 1'b0, FACE_BOTH);
    send_coin(8'd255, 8'd0, 1'b0, FACE_ONE);
    send_coin(8'd0, 8'd255, 1'b1, FACE_NONE);
    stop_coins(1);
  endtask

  // Small sizes, size 0, size 63, upper data bits ignored, and a size lowered
  // under the current fill.
  task automatic test_roll_sizes();
    write_reg(ccrc_pkg::CFG_NICKEL_SIZE, 13'd63);
    write_reg(ccrc_pkg::CFG_DIME_SIZE, 13'd0);
    write_reg(ccrc_pkg::CFG_QUARTER_SIZE, 13'h1FC2);  // only the low six bits count: 2
    write_reg(ccrc_pkg::CFG_LOONIE_SIZE, 13'd1);
    write_reg(ccrc_pkg::CFG_TOONIE_SIZE, 13'd3);
    write_reg(CFG_UNUSED_INDEX, 13'h1FFF);            // no register here
    repeat (5) send_coin(8'd100, 8'd95, 1'b0, FACE_BOTH);
    repeat (3) send_coin(8'd45, 8'd68, 1'b0, FACE_BOTH);
    repeat (3) send_coin(8'd110, 8'd115, 1'b0, FACE_BOTH);
    repeat (2) send_coin(8'd170, 8'd135, 1'b0, FACE_BOTH);
    repeat (4) send_coin(8'd190, 8'd155, 1'b0, FACE_BOTH);
    write_reg(ccrc_pkg::CFG_NICKEL_SIZE, 13'd3);      // fill already 5
    repeat (4) send_coin(8'd95, 8'd88, 1'b0, FACE_BOTH);
    stop_coins(1);
  endtask

  // Limits at zero, at full scale, and a small limit hit exactly then passed.
  task automatic test_container_limits();
    write_reg(ccrc_pkg::CFG_BENT_LIMIT, 13'd0);
    write_reg(ccrc_pkg::CFG_OTHER_LIMIT, 13'd100);
    send_coin(8'd0, 8'd10, 1'b1, FACE_NONE);      // zero weight fits a zero limit
    send_coin(8'd1, 8'd10, 1'b1, FACE_NONE);
    send_coin(8'd255, 8'd10, 1'b1, FACE_BOTH);
    send_coin(8'd60, 8'd10, 1'b0, FACE_NONE);
    send_coin(8'd40, 8'd10, 1'b0, FACE_NONE);     // sum equals the limit, no swap
    send_coin(8'd1, 8'd10, 1'b0, FACE_NONE);      // one over: swap, count restarts
    send_coin(8'd255, 8'd10, 1'b0, FACE_ONE);
    write_reg(ccrc_pkg::CFG_BENT_LIMIT, 13'd8191);
    write_reg(ccrc_pkg::CFG_OTHER_LIMIT, 13'd8191);
    repeat (6) send_coin(8'd255, 8'd200, 1'b1, FACE_NONE);
    repeat (6) send_coin(8'd255, 8'd200, 1'b0, FACE_NONE);
    stop_coins(1);
  endtask

  function automatic logic [ccrc_pkg::CFG_DATA_W-1:0] random_size_word();
    logic [ccrc_pkg::SIZE_W-1:0] sz;
    case ($urandom_range(0, 5))
      0: sz = 6'd1;
      1: sz = 6'd63;
      2: sz = 6'($urandom_range(1, 8));
      default: sz = 6'($urandom_range(1, 63));
    endcase
    return {7'($urandom_range(0, 127)), sz};
  endfunction

  function automatic logic [ccrc_pkg::CFG_DATA_W-1:0] random_limit_word();
    case ($urandom_range(0, 4))
      0: return 13'd0;
      1: return 13'd8191;
      2: return 13'($urandom_range(0, 600));
      default: return 13'($urandom_range(0, 8191));
    endcase
  endfunction

  // Several phases, each with fresh settings and its own amount of idling;
  // the first phase streams with no sender gaps at all.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      for (int i = 0; i < ccrc_pkg::NUM_ROLLS; i++)
        write_reg((ccrc_pkg::CFG_INDEX_W)'(i), random_size_word());
      write_reg(ccrc_pkg::CFG_BENT_LIMIT, random_limit_word());
      write_reg(ccrc_pkg::CFG_OTHER_LIMIT, random_limit_word());
      run_random(100, (phase == 0) ? 0 : 20 * phase);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_sorting();
    test_roll_sizes();
    test_container_limits();
    test_random_traffic();
    stop_coins(0);
    while (expected_results.size() != 0) @(posedge clk);
    // a stray beat after the last one is caught here
    repeat (16) @(posedge clk);
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  // Roughly 600 beats with worst stalls fit in well under a tenth of this.
  initial begin
    #5000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ccrc_pkg.sv
rtl/ccrc_front.sv
rtl/ccrc_queue.sv
rtl/ccrc_back.sv
rtl/coin_classify_and_roll_count_unit.sv
rtl/ccrc_checker.sv
tb/tb.sv
